// File: rtl/pgpc_pkg.sv
package pgpc_pkg;

  localparam int KIND_W    = 2;
  localparam int CHANNEL_W = 8;
  localparam int POWER_W   = 2;
  localparam int WORD_W    = 32;
  localparam int VALUE_W   = 48;
  localparam int FRAC_BITS = 16;
  localparam int ORDER_W   = 2;

  // poly_order is two bits wide, so no power above this is ever used
  localparam int MAX_POWER = 3;

  localparam int DEF_NUM_CHANNELS = 256;
  localparam int DEF_MAX_ORDER    = 3;
  localparam int DEF_SAMPLE_BITS  = 12;

  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_PED    = 2'd1,
    KIND_COEF   = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CALIB_VALID = 2'd0,
    CFG_POLY_ORDER  = 2'd1,
    CFG_THRESHOLD   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                     calib_valid;
    logic [ORDER_W-1:0]       poly_order;
    logic signed [WORD_W-1:0] threshold;
  } cfg_t;

  // classified request; data holds the table word, or the raw sample zero-extended
  typedef struct packed {
    kind_t                 op;
    logic [CHANNEL_W-1:0]  chan;
    logic [POWER_W-1:0]    pidx;
    logic [WORD_W-1:0]     data;
  } req_t;

endpackage

// File: rtl/pgpc_if.sv
interface pgpc_in_if import pgpc_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [CHANNEL_W-1:0]     channel;
  logic [POWER_W-1:0]       power_index;
  logic [SAMPLE_BITS-1:0]   raw_sample;
  logic signed [WORD_W-1:0] table_word;

  modport source (output valid, kind, channel, power_index, raw_sample, table_word,
                  input ready);
  modport sink (input valid, kind, channel, power_index, raw_sample, table_word,
                output ready);
endinterface

interface pgpc_out_if import pgpc_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [CHANNEL_W-1:0]      channel_out;
  logic signed [VALUE_W-1:0] calibrated_value;
  logic                      suppressed;
  logic                      not_calibrated;
  logic                      saturated;

  modport source (output valid, channel_out, calibrated_value, suppressed, not_calibrated,
                  saturated, input ready);
  modport sink (input valid, channel_out, calibrated_value, suppressed, not_calibrated,
                saturated, output ready);
endinterface

// File: rtl/pgpc_front.sv
module pgpc_front import pgpc_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int MAX_ORDER    = DEF_MAX_ORDER
) (
  input  logic      clk,
  input  logic      rst_n,
  pgpc_in_if.sink   in_ch,
  output logic      fr_valid,
  input  logic      fr_ready,
  output req_t      fr_req
);

  logic fr_valid_r;
  req_t fr_req_r;
  req_t req_nxt;
  logic keep;

  // drop unknown kinds, out-of-range channels and powers beyond MAX_ORDER
  always_comb begin
    req_nxt.op   = kind_t'(in_ch.kind);
    req_nxt.chan = in_ch.channel;
    req_nxt.pidx = in_ch.power_index;
    req_nxt.data = in_ch.table_word;
    keep         = 1'b0;
    case (in_ch.kind)
      KIND_SAMPLE: begin
        keep         = 1'b1;
        req_nxt.data = WORD_W'(in_ch.raw_sample);
      end
      KIND_PED:  keep = 1'b1;
      KIND_COEF: keep = (int'(in_ch.power_index) <= MAX_ORDER);
      default:   keep = 1'b0;
    endcase
    if (int'(in_ch.channel) >= NUM_CHANNELS) begin
      keep = 1'b0;
    end
  end

  assign in_ch.ready = !fr_valid_r || fr_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      fr_valid_r <= in_ch.valid && keep;
    end
    if (in_ch.ready && in_ch.valid) begin
      fr_req_r <= req_nxt;
    end
  end

  assign fr_valid = fr_valid_r;
  assign fr_req   = fr_req_r;

endmodule

// File: rtl/pgpc_queue.sv
module pgpc_queue import pgpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  req_t push_req,
  output logic pop_valid,
  input  logic pop_ready,
  output req_t pop_req
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_req    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

// File: rtl/pgpc_back.sv
module pgpc_back import pgpc_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int MAX_ORDER    = DEF_MAX_ORDER,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  output logic        q_pop,
  input  req_t        q_req,
  pgpc_out_if.source  out_ch
);

  localparam int NUM_BANKS = ((MAX_ORDER < MAX_POWER) ? MAX_ORDER : MAX_POWER) + 1;
  localparam int LAST      = NUM_BANKS - 1;
  localparam int ADDR_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ACC_W     = WORD_W + SAMPLE_BITS * (NUM_BANKS - 1) + NUM_BANKS + 1;
  localparam int MUL_W     = ACC_W + SAMPLE_BITS + 1;
  localparam int SAT_W     = (ACC_W > VALUE_W + FRAC_BITS + 1) ? ACC_W
                                                              : VALUE_W + FRAC_BITS + 1;
  localparam int CMP_W     = (SAMPLE_BITS + FRAC_BITS + 1 > WORD_W + 2)
                             ? SAMPLE_BITS + FRAC_BITS + 1 : WORD_W + 2;
  localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};
  localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};

  logic              adv;
  logic [ADDR_W-1:0] addr;

  // table read stage
  logic [WORD_W-1:0]        ped_mem [NUM_CHANNELS];
  logic signed [WORD_W-1:0] ped_rd_r;
  logic signed [WORD_W-1:0] coef_rd_r [NUM_BANKS];
  logic                     a_valid_r;
  logic [CHANNEL_W-1:0]     a_chan_r;
  logic [SAMPLE_BITS-1:0]   a_raw_r;

  // compare and Horner stages
  logic signed [CMP_W-1:0]  lhs, rhs;
  logic                     pass;
  logic signed [WORD_W-1:0] coef_m [NUM_BANKS];

  logic                     h_valid_r  [NUM_BANKS];
  logic [CHANNEL_W-1:0]     h_chan_r   [NUM_BANKS];
  logic [SAMPLE_BITS-1:0]   h_raw_r    [NUM_BANKS];
  logic                     h_supp_r   [NUM_BANKS];
  logic                     h_notcal_r [NUM_BANKS];
  logic signed [WORD_W-1:0] h_coef_r   [NUM_BANKS][NUM_BANKS];
  logic signed [ACC_W-1:0]  h_acc_r    [NUM_BANKS];

  // output stage
  logic signed [SAT_W-1:0]       ext;
  logic [SAT_W-VALUE_W-FRAC_BITS:0] top_bits;
  logic                          fits, zero;
  logic [VALUE_W-1:0]            value;
  logic                          out_valid_r;
  logic [CHANNEL_W-1:0]          out_chan_r;
  logic [VALUE_W-1:0]            out_value_r;
  logic                          out_supp_r, out_notcal_r, out_sat_r;

  // whole back end moves together; only the output register can hold it
  assign adv   = !out_valid_r || out_ch.ready;
  assign q_pop = q_valid && adv;
  assign addr  = ADDR_W'(q_req.chan);

  always_ff @(posedge clk) begin
    if (q_pop && (q_req.op == KIND_PED)) begin
      ped_mem[addr] <= q_req.data;
    end
    if (adv) begin
      ped_rd_r <= ped_mem[addr];
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [WORD_W-1:0] coef_mem [NUM_CHANNELS];

    always_ff @(posedge clk) begin
      if (q_pop && (q_req.op == KIND_COEF) && (q_req.pidx == POWER_W'(b))) begin
        coef_mem[addr] <= q_req.data;
      end
      if (adv) begin
        coef_rd_r[b] <= coef_mem[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= q_pop && (q_req.op == KIND_SAMPLE);
    end
    if (adv) begin
      a_chan_r <= q_req.chan;
      a_raw_r  <= q_req.data[SAMPLE_BITS-1:0];
    end
  end

  // raw as Q16.16 against pedestal plus threshold; powers above the order count as zero
  always_comb begin
    lhs  = $signed(CMP_W'({a_raw_r, {FRAC_BITS{1'b0}}}));
    rhs  = CMP_W'(ped_rd_r) + CMP_W'(cfg.threshold);
    pass = (lhs > rhs);
    for (int b = 0; b < NUM_BANKS; b++) begin
      coef_m[b] = (b <= int'(cfg.poly_order)) ? coef_rd_r[b] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_valid_r[0] <= 1'b0;
    end else if (adv) begin
      h_valid_r[0] <= a_valid_r;
    end
    if (adv) begin
      h_chan_r[0]   <= a_chan_r;
      h_raw_r[0]    <= a_raw_r;
      h_notcal_r[0] <= !cfg.calib_valid;
      h_supp_r[0]   <= cfg.calib_valid && !pass;
      h_acc_r[0]    <= ACC_W'(coef_m[LAST]);
      for (int b = 0; b < NUM_BANKS; b++) begin
        h_coef_r[0][b] <= coef_m[b];
      end
    end
  end

  // Horner step: acc = acc * raw + c[next lower power]
  for (genvar k = 1; k < NUM_BANKS; k++) begin : g_horner
    logic signed [MUL_W-1:0] prod;

    assign prod = h_acc_r[k-1] * $signed({1'b0, h_raw_r[k-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        h_valid_r[k] <= 1'b0;
      end else if (adv) begin
        h_valid_r[k] <= h_valid_r[k-1];
      end
      if (adv) begin
        h_chan_r[k]   <= h_chan_r[k-1];
        h_raw_r[k]    <= h_raw_r[k-1];
        h_notcal_r[k] <= h_notcal_r[k-1];
        h_supp_r[k]   <= h_supp_r[k-1];
        h_acc_r[k]    <= ACC_W'(prod) + ACC_W'(h_coef_r[k-1][LAST-k]);
        for (int b = 0; b < NUM_BANKS; b++) begin
          h_coef_r[k][b] <= h_coef_r[k-1][b];
        end
      end
    end
  end

  // drop 16 fraction bits (floor) and clamp to 48 bits
  always_comb begin
    ext      = SAT_W'(h_acc_r[LAST]);
    top_bits = ext[SAT_W-1:VALUE_W+FRAC_BITS-1];
    fits     = (&top_bits) || !(|top_bits);
    value    = fits ? ext[VALUE_W+FRAC_BITS-1:FRAC_BITS]
                    : (ext[SAT_W-1] ? VALUE_MIN : VALUE_MAX);
    zero     = h_supp_r[LAST] || h_notcal_r[LAST];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= h_valid_r[LAST];
    end
    if (adv) begin
      out_chan_r   <= h_chan_r[LAST];
      out_value_r  <= zero ? '0 : value;
      out_supp_r   <= h_supp_r[LAST];
      out_notcal_r <= h_notcal_r[LAST];
      out_sat_r    <= !zero && !fits;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.channel_out      = out_chan_r;
  assign out_ch.calibrated_value = out_value_r;
  assign out_ch.suppressed       = out_supp_r;
  assign out_ch.not_calibrated   = out_notcal_r;
  assign out_ch.saturated        = out_sat_r;

endmodule

// File: rtl/pedestal_gated_polynomial_calibration.sv
// Per-channel calibration with pedestal suppression. Table-write requests (pedestal,
// coefficient) and sample requests enter through one channel and are handled strictly in
// order, one request per cycle sustained while the output is not stalled; requests of unknown
// kinds, on channels out of range or for powers above MAX_ORDER are dropped, and samples on
// such channels give no result. Each sample that is kept gives one result. The front register
// takes the request at the accepting edge; after it come the request queue, the table read,
// the compare, one Horner multiply-add per power above zero, and the output register. The
// tables are single-port memories read once per request, which sets the one-per-cycle rate.
// A four-entry queue decouples the front from the back end, so input is taken while results
// wait, until the queue is full. Configuration must be written only while no request is in
// flight; the block itself does not enforce this.
module pedestal_gated_polynomial_calibration import pgpc_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int MAX_ORDER    = DEF_MAX_ORDER,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pgpc_in_if.sink               in_ch,
  pgpc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic fr_valid, fr_ready;
  req_t fr_req;
  logic q_valid, q_pop;
  req_t q_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.calib_valid <= 1'b0;
      cfg_r.poly_order  <= ORDER_W'(1);
      cfg_r.threshold   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CALIB_VALID: cfg_r.calib_valid <= cfg_wdata[0];
        CFG_POLY_ORDER:  cfg_r.poly_order  <= cfg_wdata[ORDER_W-1:0];
        CFG_THRESHOLD:   cfg_r.threshold   <= cfg_wdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  pgpc_front #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_ORDER    (MAX_ORDER)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr_req   (fr_req)
  );

  pgpc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_req   (fr_req),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_req    (q_req)
  );

  pgpc_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_ORDER    (MAX_ORDER),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_req   (q_req),
    .out_ch  (out_ch)
  );

endmodule
